// File: rtl/kda_pkg.sv
// Shared types and constants for the key debounce and auto-repeat block.
// Used by kda_key, kda_repeat and key_debounce_autorepeat. No dependencies.
`default_nettype none
package kda_pkg;

  localparam int unsigned NUM_KEYS = 2;
  localparam int unsigned CNT_W    = 8;
  localparam int unsigned TICK_W   = 9;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned DATA_W   = 8;

  localparam logic [CNT_W-1:0]  CNT_MAX  = 8'hFF;
  localparam logic [TICK_W-1:0] TICK_MAX = 9'h1FF;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_EMULATION_MODE      = 3'd0;
  localparam logic [IDX_W-1:0] REG_DEBOUNCE_LIMIT      = 3'd1;
  localparam logic [IDX_W-1:0] REG_SHORT_PERIOD        = 3'd2;
  localparam logic [IDX_W-1:0] REG_FAST_PERIOD         = 3'd3;
  localparam logic [IDX_W-1:0] REG_REPEATS_BEFORE_FAST = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [CNT_W-1:0] RST_DEBOUNCE_LIMIT      = 8'd1;
  localparam logic [CNT_W-1:0] RST_SHORT_PERIOD        = 8'd15;
  localparam logic [CNT_W-1:0] RST_FAST_PERIOD         = 8'd4;
  localparam logic [CNT_W-1:0] RST_REPEATS_BEFORE_FAST = 8'd4;

  // Key numbers; power wins when both keys fire on the same tick.
  localparam logic KEY_CAL   = 1'b0;
  localparam logic KEY_POWER = 1'b1;

  typedef struct packed {
    logic             emulation_mode;
    logic [CNT_W-1:0] debounce_limit;
    logic [CNT_W-1:0] short_period;
    logic [CNT_W-1:0] fast_period;
    logic [CNT_W-1:0] repeats_before_fast;
  } cfg_t;

  typedef struct packed {
    logic held;
    logic code;
  } key_stat_t;

  typedef struct packed {
    logic valid;
    logic key;
  } key_event_t;

endpackage
`default_nettype wire

// File: rtl/kda_key.sv
// Debounce counter, held flag and code bit of one key.
// Depends on kda_pkg; instantiated once per key by the top level.
`default_nettype none
module kda_key
  import kda_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      en_i,
  input  wire logic      tick_i,
  input  wire logic      pin_i,
  input  wire logic      emu_bit_i,
  input  wire cfg_t      cfg_i,
  output key_stat_t      stat_o
);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             held_q, held_d;
  logic             code_q, code_d;
  logic [CNT_W-1:0] cnt_inc, cnt_dec;
  logic             code_cur;

  always_comb begin
    cnt_inc  = (cnt_q == CNT_MAX) ? CNT_MAX : cnt_q + 1'b1;
    cnt_dec  = (cnt_q == '0) ? '0 : cnt_q - 1'b1;
    // The emulated code is latched on every item, tick or not.
    code_cur = cfg_i.emulation_mode ? emu_bit_i : code_q;
    cnt_d    = cnt_q;
    held_d   = held_q;
    code_d   = code_cur;
    if (tick_i) begin
      if (cfg_i.emulation_mode) begin
        held_d = code_cur;
      end else if (pin_i) begin
        if (cnt_inc >= cfg_i.debounce_limit) begin
          cnt_d  = cfg_i.debounce_limit;
          held_d = 1'b1;
          code_d = 1'b1;
        end else begin
          cnt_d = cnt_inc;
        end
      end else begin
        held_d = 1'b0;
        cnt_d  = cnt_dec;
        if (cnt_dec == '0) begin
          code_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      held_q <= 1'b0;
      code_q <= 1'b0;
    end else if (en_i) begin
      cnt_q  <= cnt_d;
      held_q <= held_d;
      code_q <= code_d;
    end
  end

  assign stat_o.held = held_d;
  assign stat_o.code = code_d;

  a_release_clears_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && tick_i && !cfg_i.emulation_mode && !pin_i |=> !held_q)
    else $error("held flag survived a released pin");

endmodule
`default_nettype wire

// File: rtl/kda_repeat.sv
// Typematic repeat logic: hold tick counts, repeat count and the current period.
// Depends on kda_pkg; fed with the updated held flags of both keys.
`default_nettype none
module kda_repeat
  import kda_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                tick_i,
  input  wire logic [NUM_KEYS-1:0] held_i,
  input  wire cfg_t                cfg_i,
  output key_event_t               event_o
);

  logic [TICK_W-1:0] calib_q, calib_d;
  logic [TICK_W-1:0] power_q, power_d;
  logic [CNT_W-1:0]  rep_q, rep_d;
  logic [CNT_W-1:0]  period_q, period_d;
  key_event_t        ev;

  always_comb begin
    calib_d  = calib_q;
    power_d  = power_q;
    rep_d    = rep_q;
    period_d = period_q;
    ev.valid = 1'b0;
    ev.key   = KEY_CAL;
    if (tick_i) begin
      if (held_i[0]) begin
        calib_d = (calib_q == TICK_MAX) ? TICK_MAX : calib_q + 1'b1;
      end else if (held_i[1]) begin
        power_d = (power_q == TICK_MAX) ? TICK_MAX : power_q + 1'b1;
      end else begin
        period_d = cfg_i.short_period;
        rep_d    = '0;
        calib_d  = '0;
        power_d  = '0;
      end
      if (calib_d > {1'b0, period_d}) begin
        if (rep_d >= cfg_i.repeats_before_fast) begin
          period_d = cfg_i.fast_period;
        end else begin
          rep_d = rep_d + 1'b1;
        end
        ev.valid = 1'b1;
        ev.key   = KEY_CAL;
        calib_d  = '0;
      end
      // Compared against the period after a possible switch to fast.
      if (power_d > {1'b0, period_d}) begin
        ev.valid = 1'b1;
        ev.key   = KEY_POWER;
        power_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calib_q  <= '0;
      power_q  <= '0;
      rep_q    <= '0;
      period_q <= RST_SHORT_PERIOD;
    end else if (en_i) begin
      calib_q  <= calib_d;
      power_q  <= power_d;
      rep_q    <= rep_d;
      period_q <= period_d;
    end
  end

  assign event_o = ev;

  a_release_clears_counts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && tick_i && held_i == '0 |=> calib_q == '0 && power_q == '0 && rep_q == '0)
    else $error("counts not cleared after both keys released");

endmodule
`default_nettype wire

// File: rtl/key_debounce_autorepeat.sv
// Top level of the key debounce and auto-repeat block: stream ports, config
// registers, input and result registers. Depends on kda_pkg, kda_key, kda_repeat.
//
//  Port group  Dir  Handshake                   Content
//  s_axis      in   s_axis_tvalid/tready        tick, calibration pin, power pin, emulated code
//  m_axis      out  m_axis_tvalid/tready        event_valid, event_key, key_bits
//  cfg         in   cfg_valid_i/cfg_ready_o     register index and write data
//
// Each item is held in the input register and is then processed combinationally
// into the result register, so one item is taken per clock while no result stalls.
// A stalled result holds only the result register; the input register keeps
// accepting until it also fills. Reset clears all key state and sets the config registers to their reset values.
`default_nettype none
module key_debounce_autorepeat
  import kda_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  // [0] tick, [1] calib_pin, [2] pwr_pin, [4:3] emulated_code, [7:5] zero
  input  wire logic [7:0]        s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // [0] event_valid, [1] event_key, [3:2] key_bits, [7:4] zero
  output logic [7:0]             m_axis_tdata,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [IDX_W-1:0]  cfg_index_i,
  input  wire logic [DATA_W-1:0] cfg_data_i
);

  cfg_t                cfg_q;
  logic                in_valid_q;
  logic [4:0]          in_data_q;
  logic                out_valid_q;
  logic [3:0]          out_data_q;
  logic                fire;
  logic                tick;
  logic [NUM_KEYS-1:0] pins;
  logic [NUM_KEYS-1:0] emu_code;
  key_stat_t           stat [NUM_KEYS];
  logic [NUM_KEYS-1:0] held;
  logic [NUM_KEYS-1:0] code;
  key_event_t          ev;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.emulation_mode      <= 1'b0;
      cfg_q.debounce_limit      <= RST_DEBOUNCE_LIMIT;
      cfg_q.short_period        <= RST_SHORT_PERIOD;
      cfg_q.fast_period         <= RST_FAST_PERIOD;
      cfg_q.repeats_before_fast <= RST_REPEATS_BEFORE_FAST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_EMULATION_MODE:      cfg_q.emulation_mode      <= cfg_data_i[0];
        REG_DEBOUNCE_LIMIT:      cfg_q.debounce_limit      <= cfg_data_i;
        REG_SHORT_PERIOD:        cfg_q.short_period        <= cfg_data_i;
        REG_FAST_PERIOD:         cfg_q.fast_period         <= cfg_data_i;
        REG_REPEATS_BEFORE_FAST: cfg_q.repeats_before_fast <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register; it refills in the same cycle its item moves on.
  assign fire          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data_q <= s_axis_tdata[4:0];
    end
  end

  assign tick     = in_data_q[0];
  assign pins     = in_data_q[2:1];
  assign emu_code = in_data_q[4:3];

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
    kda_key u_key (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (fire),
      .tick_i    (tick),
      .pin_i     (pins[k]),
      .emu_bit_i (emu_code[k]),
      .cfg_i     (cfg_q),
      .stat_o    (stat[k])
    );
    assign held[k] = stat[k].held;
    assign code[k] = stat[k].code;
  end

  kda_repeat u_repeat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (fire),
    .tick_i  (tick),
    .held_i  (held),
    .cfg_i   (cfg_q),
    .event_o (ev)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= {code, ev.key, ev.valid};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_data_q};

  a_key_needs_event : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q[1] |-> out_data_q[0])
    else $error("event key set without an event");

  a_full_pipe_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while both registers are stalled");

  a_fire_fills_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("processed item did not reach the result register");

endmodule
`default_nettype wire

// File: verif/tb.sv
// Self-checking testbench for key_debounce_autorepeat: stream driver, result monitor and
// a per-item predictor of debounce, hold counting and typematic repeat.
// Depends on rtl/kda_pkg.sv and rtl/key_debounce_autorepeat.sv.
module tb;
  import kda_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;
  // Indexes past the last register; writes to them must have no effect.
  localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // One scan item, packed as on s_axis_tdata from bit 0 up.
  typedef struct packed {
    logic [1:0] emulated_code;
    logic       pwr_pin;
    logic       calib_pin;
    logic       tick;
  } scan_item_t;

  // One key report, packed as on m_axis_tdata from bit 0 up.
  typedef struct packed {
    logic [1:0] key_bits;
    logic       event_key;
    logic       event_valid;
  } key_report_t;

  logic              clk_i;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [7:0]        m_axis_tdata;
  logic              cfg_valid_i   = 1'b0;
  logic              cfg_ready_o;
  logic [IDX_W-1:0]  cfg_index_i   = '0;
  logic [DATA_W-1:0] cfg_data_i    = '0;

  scan_item_t  pending_scans[$];
  key_report_t expected_reports[$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        rx_hold        = 1'b0;
  bit          hold_armed     = 1'b0;
  int unsigned fail_count     = 0;
  int unsigned cycle_count    = 0;

  // Predictor state.
  cfg_t              mdl_cfg;
  logic [CNT_W-1:0]  db_count[NUM_KEYS];
  logic              key_held[NUM_KEYS];
  logic [1:0]        code_reg;
  logic [TICK_W-1:0] calib_ticks;
  logic [TICK_W-1:0] power_ticks;
  logic [CNT_W-1:0]  repeat_cnt;
  logic [CNT_W-1:0]  period_now;

  key_debounce_autorepeat uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  task automatic reset_key_model();
    mdl_cfg = '{emulation_mode: 1'b0, debounce_limit: RST_DEBOUNCE_LIMIT,
                short_period: RST_SHORT_PERIOD, fast_period: RST_FAST_PERIOD,
                repeats_before_fast: RST_REPEATS_BEFORE_FAST};
    for (int k = 0; k < NUM_KEYS; k++) begin
      db_count[k] = '0;
      key_held[k] = 1'b0;
    end
    code_reg    = '0;
    calib_ticks = '0;
    power_ticks = '0;
    repeat_cnt  = '0;
    period_now  = RST_SHORT_PERIOD;
  endtask

  // Advances the model by one accepted scan item and returns the report it causes.
  task automatic predict_key_report(input scan_item_t scan, output key_report_t rep);
    logic pin;
    rep = '0;
    if (mdl_cfg.emulation_mode)
      code_reg = scan.emulated_code;
    if (scan.tick) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        pin = (k == 0) ? scan.calib_pin : scan.pwr_pin;
        if (mdl_cfg.emulation_mode) begin
          key_held[k] = code_reg[k];
        end else if (pin) begin
          // The count saturates before the compare, so a limit of 255 is still reachable.
          if (db_count[k] != CNT_MAX)
            db_count[k] = db_count[k] + 1'b1;
          if (db_count[k] >= mdl_cfg.debounce_limit) begin
            db_count[k] = mdl_cfg.debounce_limit;
            key_held[k] = 1'b1;
            code_reg[k] = 1'b1;
          end
        end else begin
          key_held[k] = 1'b0;
          if (db_count[k] != '0)
            db_count[k] = db_count[k] - 1'b1;
          if (db_count[k] == '0)
            code_reg[k] = 1'b0;
        end
      end
      // With both keys held only the calibration count advances.
      if (key_held[0]) begin
        if (calib_ticks != TICK_MAX)
          calib_ticks = calib_ticks + 1'b1;
      end else if (key_held[1]) begin
        if (power_ticks != TICK_MAX)
          power_ticks = power_ticks + 1'b1;
      end else begin
        period_now  = mdl_cfg.short_period;
        repeat_cnt  = '0;
        calib_ticks = '0;
        power_ticks = '0;
      end
      if (calib_ticks > {1'b0, period_now}) begin
        if (repeat_cnt >= mdl_cfg.repeats_before_fast)
          period_now = mdl_cfg.fast_period;
        else
          repeat_cnt = repeat_cnt + 1'b1;
        rep.event_valid = 1'b1;
        rep.event_key   = KEY_CAL;
        calib_ticks     = '0;
      end
      // Checked second so that power wins when both keys fire on one tick.
      if (power_ticks > {1'b0, period_now}) begin
        rep.event_valid = 1'b1;
        rep.event_key   = KEY_POWER;
        power_ticks     = '0;
      end
    end
    rep.key_bits = code_reg;
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_EMULATION_MODE:      mdl_cfg.emulation_mode      = data[0];
      REG_DEBOUNCE_LIMIT:      mdl_cfg.debounce_limit      = data;
      REG_SHORT_PERIOD:        mdl_cfg.short_period        = data;
      REG_FAST_PERIOD:         mdl_cfg.fast_period         = data;
      REG_REPEATS_BEFORE_FAST: mdl_cfg.repeats_before_fast = data;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_all_regs(input logic emu_mode, input logic [7:0] limit,
                                input logic [7:0] short_p, input logic [7:0] fast_p,
                                input logic [7:0] reps);
    write_reg(REG_EMULATION_MODE, {7'd0, emu_mode});
    write_reg(REG_DEBOUNCE_LIMIT, limit);
    write_reg(REG_SHORT_PERIOD, short_p);
    write_reg(REG_FAST_PERIOD, fast_p);
    write_reg(REG_REPEATS_BEFORE_FAST, reps);
  endtask

  task automatic queue_scans(input int unsigned n, input logic tick, input logic calib,
                             input logic power, input logic [1:0] emu);
    repeat (n)
      pending_scans.push_back('{emulated_code: emu, pwr_pin: power, calib_pin: calib,
                                tick: tick});
  endtask

  // Runs of steady key patterns with random length, dropped ticks and glitches;
  // a share of runs is heavy noise.
  task automatic queue_key_runs(input int unsigned n_items, input int unsigned tick_off_pct);
    int unsigned count;
    int unsigned run_len;
    int unsigned glitch_pct;
    logic [1:0]  keys;
    logic [1:0]  pins;
    logic [1:0]  emu;
    count = 0;
    while (count < n_items) begin
      keys       = 2'($urandom_range(3));
      run_len    = $urandom_range(1, 40);
      glitch_pct = ($urandom_range(99) < 15) ? 50 : $urandom_range(0, 5);
      repeat (run_len) begin
        pins = keys;
        emu  = keys;
        for (int k = 0; k < 2; k++) begin
          if ($urandom_range(99) < glitch_pct) pins[k] = ~pins[k];
          if ($urandom_range(99) < glitch_pct) emu[k] = ~emu[k];
        end
        pending_scans.push_back('{emulated_code: emu, pwr_pin: pins[1], calib_pin: pins[0],
                                  tick: ($urandom_range(99) >= tick_off_pct)});
      end
      count += run_len;
    end
  endtask

  task automatic wait_until_idle();
    while (pending_scans.size() != 0 || s_axis_tvalid || expected_reports.size() != 0)
      @(posedge clk_i);
    // Results pass through the input and result registers; leave a small margin before any write.
    repeat (4) @(posedge clk_i);
  endtask

  // Driver: presents pending scan items and feeds each accepted one to the predictor.
  always @(posedge clk_i) begin
    key_report_t rep;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        predict_key_report(scan_item_t'(s_axis_tdata[4:0]), rep);
        expected_reports.push_back(rep);
      end
      if (pending_scans.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, pending_scans.pop_front()};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: checks every accepted report against the oldest expected one.
  always @(posedge clk_i) begin
    key_report_t got;
    key_report_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = key_report_t'(m_axis_tdata[3:0]);
        if (expected_reports.size() == 0) begin
          $error("unexpected report, tdata %h", m_axis_tdata);
          fail_count++;
        end else begin
          want = expected_reports.pop_front();
          if (got.event_valid !== want.event_valid) begin
            $error("event_valid: expected %b, got %b", want.event_valid, got.event_valid);
            fail_count++;
          end
          if (got.event_key !== want.event_key) begin
            $error("event_key: expected %b, got %b", want.event_key, got.event_key);
            fail_count++;
          end
          if (got.key_bits !== want.key_bits) begin
            $error("key_bits: expected %b, got %b", want.key_bits, got.key_bits);
            fail_count++;
          end
        end
      end
      m_axis_tready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off so that the block backs up and stalls its input.
  initial begin
    wait (hold_armed);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (150) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("key_debounce_autorepeat regression: fail");
      $finish;
    end
  end

  initial begin
    reset_key_model();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: quick periods so that first events, the switch to fast
    // repeating and ties between keys show up within a few items.
    write_all_regs(1'b0, 8'd1, 8'd2, 8'd0, 8'd1);
    write_reg(REG_SPARE_LO, 8'hFF);
    write_reg(REG_SPARE_HI, 8'h5A);
    queue_scans(1, 1'b0, 1'b1, 1'b1, 2'b11);   // no tick: nothing may change
    queue_scans(7, 1'b1, 1'b1, 1'b0, 2'b00);   // calibration held into fast repeat
    queue_scans(3, 1'b1, 1'b1, 1'b1, 2'b10);   // both held
    queue_scans(1, 1'b1, 1'b0, 1'b0, 2'b01);   // release restores the short period
    queue_scans(5, 1'b1, 1'b0, 1'b1, 2'b00);   // power held
    queue_scans(1, 1'b1, 1'b1, 1'b1, 2'b00);   // calibration joins a power hold
    queue_scans(1, 1'b0, 1'b0, 1'b0, 2'b11);
    queue_scans(2, 1'b1, 1'b0, 1'b0, 2'b00);
    wait_until_idle();

    // Default-like periods, no idling, with the receiver hold-off.
    write_all_regs(1'b0, 8'd3, 8'd15, 8'd4, 8'd4);
    queue_key_runs(50, 8);
    hold_armed = 1'b1;
    wait_until_idle();

    // Zero debounce limit and periods at both extremes; sender mostly idle.
    write_all_regs(1'b0, 8'd0, 8'd0, 8'd255, 8'd0);
    send_idle_pct <= 75;
    queue_key_runs(40, 10);
    wait_until_idle();

    // Emulated key code with many latch-only items; receiver mostly stalled.
    write_all_regs(1'b1, 8'd2, 8'd5, 8'd1, 8'd2);
    send_idle_pct  <= 0;
    recv_stall_pct <= 75;
    queue_key_runs(50, 30);
    wait_until_idle();

    // Back to pins with the largest debounce limit and repeat count.
    write_all_regs(1'b0, 8'd255, 8'd10, 8'd2, 8'd255);
    send_idle_pct  <= 26;
    recv_stall_pct <= 26;
    queue_scans(260, 1'b1, 1'b1, 1'b0, 2'b01);
    queue_key_runs(15, 5);
    wait_until_idle();

    write_all_regs(1'b0, 8'd2, 8'd6, 8'd3, 8'd3);
    queue_key_runs(50, 10);
    wait_until_idle();

    repeat (8) @(posedge clk_i);
    if (expected_reports.size() != 0) begin
      $error("%0d expected reports never arrived", expected_reports.size());
      fail_count++;
    end
    if (fail_count == 0)
      $display("key_debounce_autorepeat regression: pass");
    else
      $display("key_debounce_autorepeat regression: fail");
    $finish;
  end

endmodule

// File: files.f
rtl/kda_pkg.sv
rtl/kda_key.sv
rtl/kda_repeat.sv
rtl/key_debounce_autorepeat.sv
verif/tb.sv
